@@ rtl/core/sdcs_pkg.sv @@
`timescale 1ns / 1ps

package sdcs_pkg;

  localparam int InDataW  = 216;
  localparam int InUserW  = 3;
  localparam int OutDataW = 136;

  typedef enum logic [4:0] {
    STEP_IDLE   = 5'd0,
    STEP_CMD0A  = 5'd1,
    STEP_CMD0B  = 5'd2,
    STEP_CMD8   = 5'd3,
    STEP_A41_55 = 5'd4,
    STEP_A41    = 5'd5,
    STEP_CID    = 5'd6,
    STEP_RCA    = 5'd7,
    STEP_CSD    = 5'd8,
    STEP_SEL    = 5'd9,
    STEP_BLEN   = 5'd10,
    STEP_BW55   = 5'd11,
    STEP_BW6    = 5'd12,
    STEP_RDM    = 5'd13,
    STEP_WR55   = 5'd14,
    STEP_WR23   = 5'd15,
    STEP_WRM    = 5'd16,
    STEP_LAST   = 5'd17
  } step_t;

  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_WRITE  = 3'd2;
  localparam logic [2:0] REQ_DONE   = 3'd3;
  localparam logic [2:0] REQ_STATUS = 3'd4;

  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_SHORT = 2'd1;
  localparam logic [1:0] RK_NOCRC = 2'd2;
  localparam logic [1:0] RK_LONG  = 2'd3;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_READ  = 2'd1;
  localparam logic [1:0] DIR_WRITE = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_CMDERR = 2'd1;
  localparam logic [1:0] STAT_OPCOND = 2'd2;
  localparam logic [1:0] STAT_BUSY   = 2'd3;

  localparam logic [3:0] DLY_NONE  = 4'd0;
  localparam logic [3:0] DLY_SHORT = 4'd1;
  localparam logic [3:0] DLY_LONG  = 4'd10;

  localparam logic [5:0] SD_CMD0  = 6'd0;
  localparam logic [5:0] SD_CMD2  = 6'd2;
  localparam logic [5:0] SD_CMD3  = 6'd3;
  localparam logic [5:0] SD_ACMD6 = 6'd6;
  localparam logic [5:0] SD_CMD7  = 6'd7;
  localparam logic [5:0] SD_CMD8  = 6'd8;
  localparam logic [5:0] SD_CMD9  = 6'd9;
  localparam logic [5:0] SD_CMD12 = 6'd12;
  localparam logic [5:0] SD_CMD13 = 6'd13;
  localparam logic [5:0] SD_CMD16 = 6'd16;
  localparam logic [5:0] SD_CMD17 = 6'd17;
  localparam logic [5:0] SD_CMD18 = 6'd18;
  localparam logic [5:0] SD_ACMD23 = 6'd23;
  localparam logic [5:0] SD_CMD24 = 6'd24;
  localparam logic [5:0] SD_CMD25 = 6'd25;
  localparam logic [5:0] SD_ACMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55 = 6'd55;

  localparam logic [31:0] ARG_IF_COND  = 32'h0000_01aa;
  localparam logic [31:0] ARG_OCR_VOLT = 32'h00f0_0000;
  localparam logic [31:0] OCR_BUSY     = 32'h8000_0000;
  localparam logic [31:0] OCR_HCS      = 32'h4000_0000;
  localparam logic [31:0] ARG_BLKLEN   = 32'd512;
  localparam logic [31:0] ARG_BUS4     = 32'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] block_address;
    logic [16:0] block_count;
    logic        completion_error;
    logic [31:0] resp_word0;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
  } item_t;

  typedef struct packed {
    logic [32:0] blocks;
    logic [31:0] kib;
  } csd_t;

  typedef struct packed {
    logic        issue;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [1:0]  response_kind;
    logic [1:0]  data_direction;
    logic [16:0] transfer_blocks;
    logic [3:0]  delay_ms;
    logic        clock_fast;
    logic [1:0]  status;
    logic        card_is_sdhc;
    logic [32:0] capacity_blocks;
    logic [31:0] capacity_kib;
  } result_t;

endpackage

@@ rtl/core/sd_card_command_sequencer_unit.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake          payload
// s_       in         s_tvalid/s_tready  s_tdata (request or completion), s_tuser (command)
// m_       out        m_tvalid/m_tready  m_tdata (command or report), m_tuser (issue)
//
// One item per cycle unless a stalled result on m_ holds the flow.
// The input register and the result register are split by the step logic and CSD decoder.
// An item with no result drains without waiting on m_tready.
// A stalled result holds the result register; the input register fills behind it.
// rst clears the step, card state and both valid flags.

module sd_card_command_sequencer_unit
  import sdcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // block_address[31:0], block_count[48:32], completion_error[49], resp_word0[81:50],
  // resp_word1[113:82], resp_word2[145:114], resp_word3[177:146], resp_word4[209:178]
  input  logic [InDataW-1:0]    s_tdata,
  // command[2:0]
  input  logic [InUserW-1:0]    s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // cmd_index[5:0], cmd_argument[37:6], response_kind[39:38], data_direction[41:40],
  // transfer_blocks[58:42], delay_ms[62:59], clock_fast[63], status[65:64],
  // card_is_sdhc[66], capacity_blocks[99:67], capacity_kib[131:100]
  output logic [OutDataW-1:0]   m_tdata,
  // issue[0]
  output logic                  m_tuser
);

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  logic    has_result;
  result_t step_result;
  result_t out_result;

  assign advance  = in_valid && (!has_result || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command          <= s_tuser;
      in_item.block_address    <= s_tdata[31:0];
      in_item.block_count      <= s_tdata[48:32];
      in_item.completion_error <= s_tdata[49];
      in_item.resp_word0       <= s_tdata[81:50];
      in_item.resp_word2       <= s_tdata[145:114];
      in_item.resp_word3       <= s_tdata[177:146];
    end
  end

  sdcs_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item       (in_item),
    .advance    (advance),
    .has_result (has_result),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_result <= step_result;
    end
  end

  assign m_tuser = out_result.issue;
  assign m_tdata = {4'd0,
                    out_result.capacity_kib,
                    out_result.capacity_blocks,
                    out_result.card_is_sdhc,
                    out_result.status,
                    out_result.clock_fast,
                    out_result.delay_ms,
                    out_result.transfer_blocks,
                    out_result.data_direction,
                    out_result.response_kind,
                    out_result.cmd_argument,
                    out_result.cmd_index};

endmodule

@@ rtl/core/sdcs_csd_decode.sv @@
`timescale 1ns / 1ps

module sdcs_csd_decode
  import sdcs_pkg::*;
(
  input  logic        sdhc,
  input  logic [31:0] resp_word2,
  input  logic [31:0] resp_word3,
  output csd_t        size
);

  logic [7:0]  byte4, byte5, byte6, byte9, byte10, byte11;
  logic [3:0]  blen_log;
  logic [22:0] hc_csize;
  logic [31:0] hc_kib;
  logic [2:0]  sc_mult;
  logic [12:0] sc_csize;
  logic [21:0] sc_blocks;

  assign byte4  = resp_word2[7:0];
  assign byte5  = resp_word2[15:8];
  assign byte6  = resp_word2[23:16];
  assign byte9  = resp_word3[15:8];
  assign byte10 = resp_word3[23:16];
  assign byte11 = resp_word3[31:24];

  assign blen_log  = byte6[3:0];
  assign hc_csize  = {1'b0, byte4[5:0], byte11, byte10} + 23'd1;
  assign hc_kib    = {hc_csize, 9'd0};
  assign sc_mult   = {byte10[1:0], byte9[7]};
  assign sc_csize  = {1'b0, byte5[1:0], byte4, byte11[7:6]} + 13'd1;
  assign sc_blocks = 22'(sc_csize) << (4'(sc_mult) + 4'd2);

  always_comb begin
    if (sdhc) begin
      size.kib = hc_kib;
      case (blen_log)
        4'd9:    size.blocks = {hc_kib, 1'b0};
        4'd10:   size.blocks = {1'b0, hc_kib};
        default: size.blocks = {2'b00, hc_kib[31:1]};
      endcase
    end else begin
      size.blocks = 33'(sc_blocks);
      case (blen_log)
        4'd9:    size.kib = 32'(sc_blocks[21:1]);
        4'd11:   size.kib = 32'({sc_blocks, 1'b0});
        default: size.kib = 32'(sc_blocks);
      endcase
    end
  end

endmodule

@@ rtl/core/sdcs_sequencer.sv @@
`timescale 1ns / 1ps

module sdcs_sequencer
  import sdcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  input  logic    advance,
  output logic    has_result,
  output result_t result
);

  step_t       step, step_next;
  logic        card_sdhc, card_sdhc_next;
  logic [15:0] rca, rca_next;
  logic        hcs, hcs_next;
  logic [31:0] saved_address, saved_address_next;
  logic [16:0] saved_count, saved_count_next;
  logic        fast_clock_on, fast_clock_on_next;
  logic [32:0] decoded_blocks, decoded_blocks_next;
  logic [31:0] decoded_kib, decoded_kib_next;
  csd_t        csd_size;
  logic        busy;
  logic        count_bad;
  logic [31:0] req_addr;

  function automatic result_t cmd_f(logic [5:0] idx, logic [31:0] arg, logic [1:0] kind,
                                    logic [1:0] dir, logic [16:0] blocks,
                                    logic [3:0] delay);
    result_t r;
    r = '0;
    r.issue           = 1'b1;
    r.cmd_index       = idx;
    r.cmd_argument    = arg;
    r.response_kind   = kind;
    r.data_direction  = dir;
    r.transfer_blocks = blocks;
    r.delay_ms        = delay;
    return r;
  endfunction

  function automatic result_t report_f(logic [1:0] stat);
    result_t r;
    r = '0;
    r.status = stat;
    return r;
  endfunction

  sdcs_csd_decode u_csd (
    .sdhc       (card_sdhc),
    .resp_word2 (item.resp_word2),
    .resp_word3 (item.resp_word3),
    .size       (csd_size)
  );

  assign busy      = (step != STEP_IDLE);
  assign count_bad = (item.block_count == 17'd0) ||
                     (item.block_count[16] && (item.block_count[15:0] != 16'd0));
  assign req_addr  = card_sdhc ? item.block_address : {item.block_address[22:0], 9'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= STEP_IDLE;
      card_sdhc      <= 1'b0;
      rca            <= '0;
      hcs            <= 1'b0;
      saved_address  <= '0;
      saved_count    <= '0;
      fast_clock_on  <= 1'b0;
      decoded_blocks <= '0;
      decoded_kib    <= '0;
    end else if (advance) begin
      step           <= step_next;
      card_sdhc      <= card_sdhc_next;
      rca            <= rca_next;
      hcs            <= hcs_next;
      saved_address  <= saved_address_next;
      saved_count    <= saved_count_next;
      fast_clock_on  <= fast_clock_on_next;
      decoded_blocks <= decoded_blocks_next;
      decoded_kib    <= decoded_kib_next;
    end
  end

  always_comb begin
    step_next           = step;
    card_sdhc_next      = card_sdhc;
    rca_next            = rca;
    hcs_next            = hcs;
    saved_address_next  = saved_address;
    saved_count_next    = saved_count;
    fast_clock_on_next  = fast_clock_on;
    decoded_blocks_next = decoded_blocks;
    decoded_kib_next    = decoded_kib;
    has_result          = 1'b0;
    result              = '0;

    if (item_valid) begin
      if (item.command == REQ_DONE) begin
        if (busy) begin
          has_result = 1'b1;
          unique case (step)
            STEP_CMD0A: begin
              result    = cmd_f(SD_CMD0, '0, RK_NONE, DIR_NONE, '0, DLY_LONG);
              step_next = STEP_CMD0B;
            end
            STEP_CMD0B: begin
              result    = cmd_f(SD_CMD8, ARG_IF_COND, RK_SHORT, DIR_NONE, '0, DLY_LONG);
              step_next = STEP_CMD8;
            end
            STEP_CMD8: begin
              hcs_next  = !item.completion_error;
              result    = cmd_f(SD_CMD55, {rca, 16'd0}, RK_SHORT, DIR_NONE, '0, DLY_NONE);
              step_next = STEP_A41_55;
            end
            STEP_A41_55: begin
              if (item.completion_error) begin
                result    = report_f(STAT_OPCOND);
                step_next = STEP_IDLE;
              end else begin
                result    = cmd_f(SD_ACMD41, ARG_OCR_VOLT | (hcs ? OCR_HCS : '0), RK_NOCRC,
                                  DIR_NONE, '0, DLY_NONE);
                step_next = STEP_A41;
              end
            end
            STEP_A41: begin
              if (item.completion_error) begin
                result    = report_f(STAT_OPCOND);
                step_next = STEP_IDLE;
              end else if ((item.resp_word0 & OCR_BUSY) != '0) begin
                card_sdhc_next = ((item.resp_word0 & OCR_HCS) != '0);
                result    = cmd_f(SD_CMD2, '0, RK_LONG, DIR_NONE, '0, DLY_NONE);
                step_next = STEP_CID;
              end else begin
                result    = cmd_f(SD_CMD55, {rca, 16'd0}, RK_SHORT, DIR_NONE, '0, DLY_LONG);
                step_next = STEP_A41_55;
              end
            end
            STEP_CID: begin
              if (item.completion_error) begin
                result    = report_f(STAT_CMDERR);
                step_next = STEP_IDLE;
              end else begin
                result    = cmd_f(SD_CMD3, '0, RK_SHORT, DIR_NONE, '0, DLY_NONE);
                step_next = STEP_RCA;
              end
            end
            STEP_RCA: begin
              if (item.completion_error) begin
                result    = report_f(STAT_CMDERR);
                step_next = STEP_IDLE;
              end else begin
                rca_next  = item.resp_word0[31:16];
                result    = cmd_f(SD_CMD9, {item.resp_word0[31:16], 16'd0}, RK_LONG,
                                  DIR_NONE, '0, DLY_NONE);
                step_next = STEP_CSD;
              end
            end
            STEP_CSD: begin
              if (item.completion_error) begin
                rca_next  = '0;
                result    = report_f(STAT_CMDERR);
                step_next = STEP_IDLE;
              end else begin
                decoded_blocks_next = csd_size.blocks;
                decoded_kib_next    = csd_size.kib;
                result    = cmd_f(SD_CMD7, {rca, 16'd0}, RK_SHORT, DIR_NONE, '0, DLY_NONE);
                step_next = STEP_SEL;
              end
            end
            STEP_SEL: begin
              if (item.completion_error) begin
                rca_next  = '0;
                result    = report_f(STAT_CMDERR);
                step_next = STEP_IDLE;
              end else begin
                fast_clock_on_next = 1'b1;
                result    = cmd_f(SD_CMD16, ARG_BLKLEN, RK_SHORT, DIR_NONE, '0, DLY_NONE);
                step_next = STEP_BLEN;
              end
            end
            STEP_BLEN: begin
              result    = cmd_f(SD_CMD55, {rca, 16'd0}, RK_SHORT, DIR_NONE, '0, DLY_NONE);
              step_next = STEP_BW55;
            end
            STEP_BW55: begin
              if (item.completion_error) begin
                result    = report_f(STAT_CMDERR);
                step_next = STEP_IDLE;
              end else begin
                result    = cmd_f(SD_ACMD6, ARG_BUS4, RK_SHORT, DIR_NONE, '0, DLY_NONE);
                step_next = STEP_BW6;
              end
            end
            STEP_BW6: begin
              if (item.completion_error) begin
                result    = report_f(STAT_CMDERR);
                step_next = STEP_IDLE;
              end else begin
                result    = cmd_f(SD_CMD13, {rca, 16'd0}, RK_SHORT, DIR_NONE, '0, DLY_NONE);
                step_next = STEP_LAST;
              end
            end
            STEP_RDM, STEP_WRM: begin
              if (item.completion_error) begin
                result    = report_f(STAT_CMDERR);
                step_next = STEP_IDLE;
              end else begin
                result    = cmd_f(SD_CMD12, '0, RK_SHORT, DIR_NONE, '0, DLY_NONE);
                step_next = STEP_LAST;
              end
            end
            STEP_WR55: begin
              if (item.completion_error) begin
                result    = report_f(STAT_CMDERR);
                step_next = STEP_IDLE;
              end else begin
                result    = cmd_f(SD_ACMD23, 32'(saved_count), RK_SHORT, DIR_NONE, '0,
                                  DLY_NONE);
                step_next = STEP_WR23;
              end
            end
            STEP_WR23: begin
              if (item.completion_error) begin
                result    = report_f(STAT_CMDERR);
                step_next = STEP_IDLE;
              end else begin
                result    = cmd_f(SD_CMD25, saved_address, RK_SHORT, DIR_WRITE, saved_count,
                                  DLY_NONE);
                step_next = STEP_WRM;
              end
            end
            STEP_LAST: begin
              result    = report_f(item.completion_error ? STAT_CMDERR : STAT_OK);
              step_next = STEP_IDLE;
            end
            default: begin
              has_result = 1'b0;
              step_next  = STEP_IDLE;
            end
          endcase
        end
      end else if (item.command == REQ_INIT || item.command == REQ_READ ||
                   item.command == REQ_WRITE || item.command == REQ_STATUS) begin
        has_result = 1'b1;
        if (busy) begin
          result = report_f(STAT_BUSY);
        end else if (item.command == REQ_INIT) begin
          card_sdhc_next      = 1'b0;
          rca_next            = '0;
          hcs_next            = 1'b0;
          fast_clock_on_next  = 1'b0;
          decoded_blocks_next = '0;
          decoded_kib_next    = '0;
          result    = cmd_f(SD_CMD0, '0, RK_NONE, DIR_NONE, '0, DLY_SHORT);
          step_next = STEP_CMD0A;
        end else if (item.command == REQ_STATUS) begin
          result    = cmd_f(SD_CMD13, {rca, 16'd0}, RK_SHORT, DIR_NONE, '0, DLY_NONE);
          step_next = STEP_LAST;
        end else if (count_bad) begin
          result    = report_f(STAT_CMDERR);
          step_next = STEP_IDLE;
        end else begin
          saved_address_next = req_addr;
          saved_count_next   = item.block_count;
          if (item.command == REQ_READ) begin
            if (item.block_count == 17'd1) begin
              result    = cmd_f(SD_CMD17, req_addr, RK_SHORT, DIR_READ, 17'd1, DLY_NONE);
              step_next = STEP_LAST;
            end else begin
              result    = cmd_f(SD_CMD18, req_addr, RK_SHORT, DIR_READ, item.block_count,
                                DLY_NONE);
              step_next = STEP_RDM;
            end
          end else if (item.block_count == 17'd1) begin
            result    = cmd_f(SD_CMD24, req_addr, RK_SHORT, DIR_WRITE, 17'd1, DLY_NONE);
            step_next = STEP_LAST;
          end else begin
            result    = cmd_f(SD_CMD55, {rca, 16'd0}, RK_SHORT, DIR_NONE, '0, DLY_NONE);
            step_next = STEP_WR55;
          end
        end
      end
    end

    result.clock_fast = fast_clock_on_next;
    if (!result.issue) begin
      result.card_is_sdhc    = card_sdhc_next;
      result.capacity_blocks = decoded_blocks_next;
      result.capacity_kib    = decoded_kib_next;
    end
  end

endmodule

@@ rtl/core/sdcs_checker.sv @@
`timescale 1ns / 1ps

module sdcs_checker
  import sdcs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic                m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_issue_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[131:64] == '0)
    else $error("command carries report fields");

  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[62:0] == '0)
    else $error("report carries command fields");

  a_delay: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[62:59] == DLY_NONE || m_tdata[62:59] == DLY_SHORT ||
      m_tdata[62:59] == DLY_LONG)
    else $error("bad command delay");

endmodule

bind sd_card_command_sequencer_unit sdcs_checker u_sdcs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
